@@ sv/fms_pkg.sv @@
`timescale 1ns / 1ps

package fms_pkg;

    localparam int SVC_W   = 4;
    localparam int COUNT_W = 4;
    localparam int MASK_W  = 3;

    typedef logic [SVC_W-1:0]   svc_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [MASK_W-1:0]  mask_t;

    typedef struct packed {
        logic arrival_valid;
        svc_t service_ticks;
    } arrival_t;

    typedef struct packed {
        logic   arrival_dropped;
        mask_t  started_mask;
        mask_t  finished_mask;
        mask_t  busy_mask;
        count_t queue_count;
    } result_t;

    // Status of the job queue for the word being processed.
    typedef struct packed {
        logic   dropped;
        count_t queue_count;
    } q_status_t;

    // Per-server event masks for the word being processed.
    typedef struct packed {
        mask_t started;
        mask_t finished;
        mask_t busy;
    } srv_status_t;

endpackage

@@ sv/fms_if.sv @@
`timescale 1ns / 1ps

interface fms_arrival_if;
    import fms_pkg::*;

    logic     valid;
    logic     ready;
    arrival_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fms_result_if;
    import fms_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/fms_job_queue.sv @@
`timescale 1ns / 1ps

module fms_job_queue #(
    parameter int QUEUE_SLOTS = 16,
    parameter int NUM_SERVERS = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 push_req,
    input  fms_pkg::svc_t                        push_data,
    input  logic [$clog2(NUM_SERVERS+1)-1:0]     pop_cnt,
    output logic [$clog2(NUM_SERVERS+1)-1:0]     avail,
    output fms_pkg::svc_t                        window [NUM_SERVERS],
    output fms_pkg::q_status_t                   status
);
    import fms_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_SLOTS);
    localparam int PW    = $clog2(NUM_SERVERS + 1);
    localparam int DEPTH = QUEUE_SLOTS - 1;

    // Collapsing queue: entry 0 is always the head job.
    svc_t             entry_reg  [DEPTH];
    svc_t             entry_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             accept;
    int               total;

    assign full   = (int'(count_reg) == DEPTH);
    assign accept = push_req && !full;
    assign total  = int'(count_reg) + int'(accept);
    assign avail  = (total > NUM_SERVERS) ? PW'(NUM_SERVERS) : PW'(total);

    assign count_next = CNT_W'(int'(count_reg) + int'(accept) - int'(pop_cnt));

    assign status.dropped     = push_req && full;
    assign status.queue_count = COUNT_W'(count_next);

    // The arriving job sits right behind the stored entries, so a server can
    // take it in the same tick.
    for (genvar j = 0; j < NUM_SERVERS; j++) begin : g_window
        if (j < DEPTH) begin : g_stored
            assign window[j] = (j < int'(count_reg)) ? entry_reg[j] : push_data;
        end
        else begin : g_arrival
            assign window[j] = push_data;
        end
    end

    // Entries past the new length are never read, so they may take any value.
    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        always_comb
        begin
            entry_next[k] = push_data;
            for (int s = 0; s <= NUM_SERVERS; s++)
            begin
                if (int'(pop_cnt) == s && k + s < DEPTH && k + s < int'(count_reg))
                begin
                    entry_next[k] = entry_reg[k + s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/fms_server_bank.sv @@
`timescale 1ns / 1ps

module fms_server_bank #(
    parameter int NUM_SERVERS = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [$clog2(NUM_SERVERS+1)-1:0] avail,
    input  fms_pkg::svc_t                    window [NUM_SERVERS],
    output logic [$clog2(NUM_SERVERS+1)-1:0] pop_cnt,
    output fms_pkg::srv_status_t             status,
    output logic [NUM_SERVERS-1:0]           busy_state
);
    import fms_pkg::*;

    localparam int PW = $clog2(NUM_SERVERS + 1);

    logic [NUM_SERVERS-1:0] busy_reg;
    logic [NUM_SERVERS-1:0] busy_next;
    svc_t                   rem_reg  [NUM_SERVERS];
    svc_t                   rem_next [NUM_SERVERS];

    // Servers are served in fixed order; each idle one takes the next job.
    always_comb
    begin
        logic [PW-1:0] pops;
        logic          start;
        logic          active;
        svc_t          rem;
        svc_t          dec;
        svc_t          job;

        pops   = '0;
        status = '0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            start = !busy_reg[i] && (pops < avail);
            job   = window[0];
            for (int j = 0; j < NUM_SERVERS; j++)
            begin
                if (pops == PW'(j))
                begin
                    job = window[j];
                end
            end
            if (start)
            begin
                pops = pops + PW'(1);
            end
            rem    = start ? job : rem_reg[i];
            active = busy_reg[i] || start;
            dec    = rem - SVC_W'(1);
            rem_next[i]  = active ? dec : rem_reg[i];
            busy_next[i] = active && (dec != '0);
            if (i < MASK_W)
            begin
                status.started[i]  = start;
                status.finished[i] = active && (dec == '0);
                status.busy[i]     = active && (dec != '0);
            end
        end
        pop_cnt = pops;
    end

    assign busy_state = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

@@ sv/fifo_multi_server_dispatch_top.sv @@
`timescale 1ns / 1ps

// Job queue feeding a row of servers, one tick per arrival word. Each word may
// carry a job that is appended to a queue of QUEUE_SLOTS-1 jobs (dropped and
// flagged when full); idle servers then take head jobs in order 0 upward and
// every busy server counts down, so a job of length 1 starts and ends in the
// same tick. Exactly one result word comes out per arrival word. The block
// takes one word per clock cycle while results.ready is high; each word goes
// through an input register, then the queue update and the server priority
// chain in one pass into the result register. Only servers 0 to 2 show in
// the masks and queue_count carries the low four bits of the queue length.
module fifo_multi_server_dispatch_top #(
    parameter int QUEUE_SLOTS = 16,
    parameter int NUM_SERVERS = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    fms_arrival_if.sink    arrivals,
    fms_result_if.source   results
);
    import fms_pkg::*;

    localparam int PW = $clog2(NUM_SERVERS + 1);

    logic                   in_valid_reg;
    arrival_t               in_data_reg;
    logic                   out_valid_reg;
    result_t                out_data_reg;
    logic                   advance;
    logic [PW-1:0]          avail;
    logic [PW-1:0]          pop_cnt;
    svc_t                   window [NUM_SERVERS];
    q_status_t              q_stat;
    srv_status_t            s_stat;
    logic [NUM_SERVERS-1:0] busy_state;
    mask_t                  busy_view;

    assign advance        = in_valid_reg && (!out_valid_reg || results.ready);
    assign arrivals.ready = !in_valid_reg || advance;
    assign results.valid  = out_valid_reg;
    assign results.data   = out_data_reg;

    fms_job_queue #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .NUM_SERVERS (NUM_SERVERS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .push_req  (in_data_reg.arrival_valid),
        .push_data (in_data_reg.service_ticks),
        .pop_cnt   (pop_cnt),
        .avail     (avail),
        .window    (window),
        .status    (q_stat)
    );

    fms_server_bank #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_servers (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .avail      (avail),
        .window     (window),
        .pop_cnt    (pop_cnt),
        .status     (s_stat),
        .busy_state (busy_state)
    );

    always_comb
    begin
        busy_view = '0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            if (i < MASK_W)
            begin
                busy_view[i] = busy_state[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (arrivals.valid && arrivals.ready)
        begin
            in_data_reg <= arrivals.data;
        end
        if (advance)
        begin
            out_data_reg.arrival_dropped <= q_stat.dropped;
            out_data_reg.started_mask    <= s_stat.started;
            out_data_reg.finished_mask   <= s_stat.finished;
            out_data_reg.busy_mask       <= s_stat.busy;
            out_data_reg.queue_count     <= q_stat.queue_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (arrivals.ready)
            begin
                in_valid_reg <= arrivals.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // The reported busy mask is the server state left behind by that tick.
    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> results.data.busy_mask == busy_view)
        else $error("busy mask differs from server state");

    // A server only takes a job when it was idle before the tick.
    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (results.data.started_mask & $past(busy_view)) == '0)
        else $error("busy server started a new job");

    // A server that finished is idle afterwards.
    a_finish_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.data.finished_mask & results.data.busy_mask) == '0)
        else $error("server both finished and busy");
`endif

endmodule
